// ===== hw/rtl/fds_pkg.sv =====
// shared types, constants and codes for the delimited field splitter
package fds_pkg;

   localparam int HELD_SPACE_DEPTH = 31;
   localparam int HS_CNT_W = $clog2(HELD_SPACE_DEPTH + 1);
   localparam int HS_IDX_W = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

   localparam int CMD_FIFO_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_FIFO_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] WS_DELIM = 8'd115;
   localparam logic [7:0] BACKSLASH = 8'd92;

   localparam logic [7:0] DELIMITER_RESET = 8'd44;

   // register indexes
   localparam logic [1:0] REG_DELIMITER = 2'd0;
   localparam logic [1:0] REG_REMOVE_EMPTY = 2'd1;
   localparam logic [1:0] REG_HANDLE_ESCAPE = 2'd2;
   localparam logic [1:0] REG_FIELD_LIMIT = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_STRING_END = 2'd2;

   typedef struct packed {
      logic [7:0] char_in;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [7:0] field_number;
      logic       held_overflow;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] delimiter;
      logic       remove_empty;
      logic       handle_escape;
      logic [7:0] field_limit;
   } cfg_type;

   // one item's worth of work for the back end, emitted in this order:
   // held whitespace, the byte, up to two field ends, string end
   typedef struct packed {
      logic [HS_CNT_W-1:0] rel_n;
      logic                has_byte;
      logic [7:0]          char_val;
      logic [7:0]          fnum_a;
      logic                ovf_a;
      logic [1:0]          close_n;
      logic [7:0]          fnum_c0;
      logic                ovf_c0;
      logic [7:0]          fnum_c1;
      logic                has_end;
      logic [7:0]          fnum_end;
   } cmd_type;

   typedef struct packed {
      logic [HS_IDX_W-1:0] addr;
      logic                rel_done;
   } hold_rd_type;

endpackage

// ===== hw/rtl/fds_front.sv =====
// front end: takes input bytes, tracks field state, holds whitespace, issues commands
module fds_front (
   input  logic                 clock,
   input  logic                 reset,
   input  fds_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fds_pkg::req_type     req_data,
   output logic                 push,
   output fds_pkg::cmd_type     push_data,
   input  logic                 fifo_full,
   input  fds_pkg::hold_rd_type hold_rd,
   output logic [7:0]           hold_rd_data
);
   import fds_pkg::*;

   typedef struct packed {
      logic [7:0]          fe;
      logic                esc;
      logic                started;
      logic                raw;
      logic                rem;
      logic [HS_CNT_W-1:0] cnt;
      logic                ovf;
   } split_state_type;

   split_state_type st_ff, st_in;
   logic            rel_pend_ff, rel_pend_in;
   logic [7:0]      hold_ff [HELD_SPACE_DEPTH];

   cmd_type    cmd;
   logic       accept;
   logic       hold_we;
   logic       is_bs;
   logic       delim_hit;
   logic       c_en;
   logic [7:0] c_b;
   logic       do_delim;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic split_state_type clear_fld(input split_state_type s);
      split_state_type r;
      r = s;
      r.started = 1'b0;
      r.raw = 1'b0;
      r.cnt = '0;
      r.ovf = 1'b0;
      r.esc = 1'b0;
      return r;
   endfunction

   function automatic split_state_type after_close(input split_state_type s);
      split_state_type r;
      r = clear_fld(s);
      if (s.fe != 8'd255) begin
         r.fe = s.fe + 8'd1;
      end
      return r;
   endfunction

   function automatic cmd_type add_close(input cmd_type c, input split_state_type s);
      cmd_type r;
      r = c;
      if (c.close_n == 2'd0) begin
         r.fnum_c0 = s.fe;
         r.ovf_c0 = s.ovf;
      end else begin
         r.fnum_c1 = s.fe;
      end
      r.close_n = c.close_n + 2'd1;
      return r;
   endfunction

   assign req_stall = rel_pend_ff || fifo_full;
   assign accept = req_valid && !req_stall;

   assign is_bs = (req_data.char_in == BACKSLASH);
   assign delim_hit = (cfg.delimiter == WS_DELIM) ? is_ws(req_data.char_in)
                                                   : (req_data.char_in == cfg.delimiter);

   always_comb begin
      st_in = st_ff;
      cmd = '0;
      hold_we = 1'b0;

      // which byte, if any, goes through the field content path
      if (req_data.string_end) begin
         c_en = !st_ff.rem && st_ff.esc && (cfg.delimiter != BACKSLASH);
         c_b = BACKSLASH;
         do_delim = !st_ff.rem && st_ff.esc && (cfg.delimiter == BACKSLASH);
      end else begin
         c_en = st_ff.rem || st_ff.esc || (!(cfg.handle_escape && is_bs) && !delim_hit);
         c_b = req_data.char_in;
         do_delim = !st_ff.rem && !st_ff.esc && !(cfg.handle_escape && is_bs) && delim_hit;
      end

      if (c_en) begin
         st_in.esc = 1'b0;
         st_in.raw = 1'b1;
         if (cfg.handle_escape && c_b == BACKSLASH) begin
            // backslash is dropped
         end else if (is_ws(c_b)) begin
            if (st_ff.started) begin
               if (st_ff.cnt < HS_CNT_W'(HELD_SPACE_DEPTH)) begin
                  hold_we = 1'b1;
                  st_in.cnt = st_ff.cnt + HS_CNT_W'(1);
               end else begin
                  st_in.ovf = 1'b1;
               end
            end
         end else begin
            cmd.rel_n = st_ff.cnt;
            cmd.has_byte = 1'b1;
            cmd.char_val = c_b;
            cmd.fnum_a = st_ff.fe;
            cmd.ovf_a = st_ff.ovf;
            st_in.cnt = '0;
            st_in.started = 1'b1;
         end
      end

      if (!req_data.string_end && !st_ff.rem && !st_ff.esc && cfg.handle_escape && is_bs) begin
         st_in.esc = 1'b1;
      end

      if (req_data.string_end && st_ff.rem) begin
         cmd = add_close(cmd, st_in);
         st_in = after_close(st_in);
      end else if (do_delim) begin
         st_in.esc = 1'b0;
         if (!cfg.remove_empty || st_in.raw) begin
            cmd = add_close(cmd, st_in);
            st_in = after_close(st_in);
         end else begin
            st_in = clear_fld(st_in);
         end
         if (cfg.field_limit != 8'd0 && st_in.fe == cfg.field_limit - 8'd1) begin
            st_in.rem = 1'b1;
         end
         // a backslash delimiter at string end closes a remainder it opened
         if (req_data.string_end && st_in.rem) begin
            cmd = add_close(cmd, st_in);
            st_in = after_close(st_in);
         end
      end else if (req_data.string_end) begin
         if (st_in.raw || (!cfg.remove_empty && st_in.fe == 8'd0)) begin
            cmd = add_close(cmd, st_in);
            st_in = after_close(st_in);
         end
      end

      if (req_data.string_end) begin
         cmd.has_end = 1'b1;
         cmd.fnum_end = st_in.fe;
         st_in.fe = 8'd0;
         st_in.rem = 1'b0;
         st_in = clear_fld(st_in);
      end
   end

   assign push = accept && (cmd.has_byte || cmd.close_n != 2'd0 || cmd.has_end);
   assign push_data = cmd;

   // held bytes stay frozen until the back end has released them
   always_comb begin
      rel_pend_in = rel_pend_ff;
      if (push && cmd.rel_n != '0) begin
         rel_pend_in = 1'b1;
      end else if (hold_rd.rel_done) begin
         rel_pend_in = 1'b0;
      end
   end

   assign hold_rd_data = (32'(hold_rd.addr) < HELD_SPACE_DEPTH) ? hold_ff[hold_rd.addr] : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         rel_pend_ff <= 1'b0;
      end else begin
         rel_pend_ff <= rel_pend_in;
         if (accept) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold_we) begin
         hold_ff[st_ff.cnt[HS_IDX_W-1:0]] <= c_b;
      end
   end

endmodule

// ===== hw/rtl/fds_cmd_fifo.sv =====
// small command queue between front and back ends
module fds_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fds_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output fds_pkg::cmd_type head,
   output logic             empty
);
   import fds_pkg::*;

   cmd_type              mem_ff [CMD_FIFO_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full = (count_ff == CMD_CNT_W'(CMD_FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == CMD_FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == CMD_FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/fds_back.sv =====
// back end: walks each command and emits one result per cycle into the output register while rsp is not stalled
module fds_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fds_pkg::cmd_type     cmd,
   input  logic                 fifo_empty,
   output logic                 pop,
   output fds_pkg::hold_rd_type hold_rd,
   input  logic [7:0]           hold_rd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fds_pkg::rsp_type     rsp_data
);
   import fds_pkg::*;

   logic [HS_CNT_W-1:0] rel_idx_ff, rel_idx_in;
   logic                byte_done_ff, byte_done_in;
   logic [1:0]          close_done_ff, close_done_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff;

   rsp_type evt;
   logic    take;
   logic    last;

   assign take = !fifo_empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      evt = '0;
      last = 1'b0;
      rel_idx_in = rel_idx_ff;
      byte_done_in = byte_done_ff;
      close_done_in = close_done_ff;
      if (rel_idx_ff < cmd.rel_n) begin
         evt.kind = KIND_BYTE;
         evt.char_out = hold_rd_data;
         evt.field_number = cmd.fnum_a;
         evt.held_overflow = cmd.ovf_a;
         rel_idx_in = rel_idx_ff + HS_CNT_W'(1);
      end else if (cmd.has_byte && !byte_done_ff) begin
         evt.kind = KIND_BYTE;
         evt.char_out = cmd.char_val;
         evt.field_number = cmd.fnum_a;
         evt.held_overflow = cmd.ovf_a;
         last = (cmd.close_n == 2'd0) && !cmd.has_end;
         byte_done_in = 1'b1;
      end else if (close_done_ff < cmd.close_n) begin
         evt.kind = KIND_FIELD_END;
         evt.field_number = (close_done_ff == 2'd0) ? cmd.fnum_c0 : cmd.fnum_c1;
         evt.held_overflow = (close_done_ff == 2'd0) ? cmd.ovf_c0 : 1'b0;
         last = ((close_done_ff + 2'd1) == cmd.close_n) && !cmd.has_end;
         close_done_in = close_done_ff + 2'd1;
      end else begin
         evt.kind = KIND_STRING_END;
         evt.field_number = cmd.fnum_end;
         last = 1'b1;
      end
      evt.run_last = last;
      if (last) begin
         rel_idx_in = '0;
         byte_done_in = 1'b0;
         close_done_in = 2'd0;
      end
   end

   assign pop = take && last;
   assign hold_rd.addr = rel_idx_ff[HS_IDX_W-1:0];
   assign hold_rd.rel_done = take && last && (cmd.rel_n != '0);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_idx_ff <= '0;
         byte_done_ff <= 1'b0;
         close_done_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            rel_idx_ff <= rel_idx_in;
            byte_done_ff <= byte_done_in;
            close_done_ff <= close_done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= evt;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

// ===== hw/rtl/delimited_field_splitter_core.sv =====
// top level: register port, front end, command queue, back end
// path: the first result of an item is registered in the command queue and then in the output
//   register, from which it is offered on rsp
// throughput: one input transfer per cycle while the command queue has room; the back end
//   sends one result per cycle while rsp is not stalled, and an item that releases held
//   whitespace blocks req until the back end has taken that item's last result
// reset: synchronous; clears field state, queue and output register and loads register
//   defaults; the held whitespace buffer is not cleared
module delimited_field_splitter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fds_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fds_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fds_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fds_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fds_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import fds_pkg::*;

   cfg_type     cfg_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   logic        push;
   cmd_type     push_data;
   logic        fifo_full;
   logic        fifo_empty;
   logic        pop;
   cmd_type     head;
   hold_rd_type hold_rd;
   logic [7:0]  hold_rd_data;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter <= DELIMITER_RESET;
         cfg_ff.remove_empty <= 1'b0;
         cfg_ff.handle_escape <= 1'b0;
         cfg_ff.field_limit <= 8'd0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DELIMITER: cfg_ff.delimiter <= pwdata[7:0];
            REG_REMOVE_EMPTY: cfg_ff.remove_empty <= pwdata[0];
            REG_HANDLE_ESCAPE: cfg_ff.handle_escape <= pwdata[0];
            REG_FIELD_LIMIT: cfg_ff.field_limit <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DELIMITER: prdata = {24'd0, cfg_ff.delimiter};
         REG_REMOVE_EMPTY: prdata = {31'd0, cfg_ff.remove_empty};
         REG_HANDLE_ESCAPE: prdata = {31'd0, cfg_ff.handle_escape};
         REG_FIELD_LIMIT: prdata = {24'd0, cfg_ff.field_limit};
         default: prdata = '0;
      endcase
   end

   fds_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .push         (push),
      .push_data    (push_data),
      .fifo_full    (fifo_full),
      .hold_rd      (hold_rd),
      .hold_rd_data (hold_rd_data)
   );

   fds_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .head      (head),
      .empty     (fifo_empty)
   );

   fds_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd          (head),
      .fifo_empty   (fifo_empty),
      .pop          (pop),
      .hold_rd      (hold_rd),
      .hold_rd_data (hold_rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   // a command is never offered to a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("command pushed into full queue");

   // string end carries no byte and no overflow flag
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STRING_END |->
         !rsp_data.held_overflow && rsp_data.char_out == 8'd0)
      else $error("string end with byte or overflow flag");

   // string end is always the final result of its item
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STRING_END |-> rsp_data.run_last)
      else $error("string end not marked last");

   // the queue pops only when it holds something and the output register has room
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_empty && (!rsp_valid || !rsp_stall))
      else $error("command popped without a result slot");

endmodule

// ===== dv/delimited_field_splitter_checker.sv =====
// result checker for the delimited field splitter: predicts and compares every rsp transfer
module delimited_field_splitter_checker
   import fds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    results_due
);

   // register copies
   logic [7:0] delim_cfg;
   logic       drop_empty_cfg;
   logic       escape_cfg;
   logic [7:0] limit_cfg;

   // field and string state
   logic [7:0] field_count;
   logic       esc_pending;
   logic       field_open;
   logic       span_seen;
   logic       rest_mode;
   logic [7:0] held_ws [HELD_SPACE_DEPTH];
   int         held_n;
   logic       held_lost;

   rsp_type    split_results[$];
   rsp_type    item_results[$];

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   task automatic emit(input logic [1:0] kind, input logic [7:0] ch);
      rsp_type r;
      r.kind = kind;
      r.char_out = ch;
      r.field_number = field_count;
      r.held_overflow = (kind == KIND_STRING_END) ? 1'b0 : held_lost;
      r.run_last = 1'b0;
      item_results.push_back(r);
   endtask

   task automatic clear_field_state();
      field_open = 1'b0;
      span_seen = 1'b0;
      held_n = 0;
      held_lost = 1'b0;
      esc_pending = 1'b0;
   endtask

   task automatic end_field();
      emit(KIND_FIELD_END, 8'd0);
      if (field_count != 8'd255) begin
         field_count = field_count + 8'd1;
      end
      clear_field_state();
   endtask

   task automatic take_byte(input logic [7:0] b);
      int i;
      span_seen = 1'b1;
      if (escape_cfg && b == BACKSLASH) begin
         // backslashes never reach the output
      end else if (is_space(b)) begin
         if (field_open) begin
            if (held_n < HELD_SPACE_DEPTH) begin
               held_ws[held_n] = b;
               held_n++;
            end else begin
               held_lost = 1'b1;
            end
         end
      end else begin
         for (i = 0; i < held_n; i++) begin
            emit(KIND_BYTE, held_ws[i]);
         end
         held_n = 0;
         field_open = 1'b1;
         emit(KIND_BYTE, b);
      end
   endtask

   task automatic delimiter_hit();
      if (!drop_empty_cfg || span_seen) begin
         end_field();
      end else begin
         clear_field_state();
      end
      // field limit reached: the rest of the string is one field
      if (limit_cfg != 8'd0 && field_count == limit_cfg - 8'd1) begin
         rest_mode = 1'b1;
      end
   endtask

   task automatic split_item(input req_type item);
      logic [7:0] ch;
      rsp_type    r;
      ch = item.char_in;
      item_results.delete();
      if (item.string_end) begin
         if (rest_mode) begin
            end_field();
         end else if (esc_pending && delim_cfg == BACKSLASH) begin
            // dangling backslash acts as the delimiter
            esc_pending = 1'b0;
            delimiter_hit();
            if (rest_mode) begin
               end_field();
            end
         end else begin
            if (esc_pending) begin
               esc_pending = 1'b0;
               take_byte(BACKSLASH);
            end
            if (span_seen || (!drop_empty_cfg && field_count == 8'd0)) begin
               end_field();
            end
         end
         emit(KIND_STRING_END, 8'd0);
         field_count = 8'd0;
         rest_mode = 1'b0;
         clear_field_state();
      end else if (rest_mode) begin
         take_byte(ch);
      end else if (esc_pending) begin
         esc_pending = 1'b0;
         take_byte(ch);
      end else if (escape_cfg && ch == BACKSLASH) begin
         esc_pending = 1'b1;
      end else if (delim_cfg == WS_DELIM ? is_space(ch) : ch == delim_cfg) begin
         delimiter_hit();
      end else begin
         take_byte(ch);
      end
      if (item_results.size() > 0) begin
         r = item_results.pop_back();
         r.run_last = 1'b1;
         item_results.push_back(r);
      end
      while (item_results.size() > 0) begin
         split_results.push_back(item_results.pop_front());
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         delim_cfg = DELIMITER_RESET;
         drop_empty_cfg = 1'b0;
         escape_cfg = 1'b0;
         limit_cfg = 8'd0;
         field_count = 8'd0;
         rest_mode = 1'b0;
         clear_field_state();
         split_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (split_results.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = split_results.pop_front();
               check_field("kind", {6'd0, want.kind}, {6'd0, rsp_data.kind});
               check_field("char_out", want.char_out, rsp_data.char_out);
               check_field("field_number", want.field_number, rsp_data.field_number);
               check_field("held_overflow", {7'd0, want.held_overflow},
                           {7'd0, rsp_data.held_overflow});
               check_field("run_last", {7'd0, want.run_last}, {7'd0, rsp_data.run_last});
            end
         end
         if (req_valid && !req_stall) begin
            split_item(req_data);
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_DELIMITER: begin
                  delim_cfg = pwdata[7:0];
               end
               REG_REMOVE_EMPTY: begin
                  drop_empty_cfg = pwdata[0];
               end
               REG_HANDLE_ESCAPE: begin
                  escape_cfg = pwdata[0];
               end
               REG_FIELD_LIMIT: begin
                  limit_cfg = pwdata[7:0];
               end
               default: begin
               end
            endcase
         end
      end
      results_due <= split_results.size();
   end

endmodule

// ===== dv/tb_delimited_field_splitter_core.sv =====
// testbench top for the delimited field splitter: stimulus, register setup and verdict
module tb_delimited_field_splitter_core;
   import fds_pkg::*;

   localparam int ITEM_TARGET = 410;
   localparam int TAIL_ITEMS = 80;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int LIMIT_CYCLES = 400000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int         mismatch_count;
   int         results_due;
   int         items_sent;
   logic [7:0] cur_delim;
   bit         quiet_tail;
   bit         hold_request;

   delimited_field_splitter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   delimited_field_splitter_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] pick_space();
      int k;
      k = $urandom_range(0, 7);
      return (k >= 5) ? 8'd32 : 8'(9 + k);
   endfunction

   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
         return (cur_delim == WS_DELIM) ? pick_space() : cur_delim;
      end else if (roll < 36) begin
         return pick_space();
      end else if (roll < 46) begin
         return BACKSLASH;
      end else if (roll < 70) begin
         return 8'(97 + $urandom_range(0, 25));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // holds the transfer until accepted, then maybe leaves a gap
   task automatic send_item(input logic [7:0] ch, input logic fin);
      req_type item;
      item.char_in = ch;
      item.string_end = fin;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // waits until every expected result is in and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] delim, input logic drop, input logic esc,
                             input logic [7:0] limit);
      settle();
      write_reg(REG_DELIMITER, delim);
      write_reg(REG_REMOVE_EMPTY, {7'd0, drop});
      write_reg(REG_HANDLE_ESCAPE, {7'd0, esc});
      write_reg(REG_FIELD_LIMIT, limit);
      cur_delim = delim;
   endtask

   task automatic send_random_string(input bit long_space);
      int len;
      int i;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      if (long_space) begin
         // whitespace run from just under to past the held buffer depth inside one field
         send_item(8'(97 + $urandom_range(0, 25)), 1'b0);
         repeat ($urandom_range(HELD_SPACE_DEPTH - 3, HELD_SPACE_DEPTH + 8)) begin
            send_item(pick_space(), 1'b0);
         end
         send_item(8'(97 + $urandom_range(0, 25)), 1'b0);
      end
      for (i = 0; i < len; i++) begin
         send_item(pick_byte(), 1'b0);
      end
      send_end();
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : result_backpressure
      int span;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (quiet_tail) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            span = 0;
            while (span < HOLD_OFF_CYCLES) begin
               @(posedge clock);
               span++;
            end
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int phase;
      int n_str;
      int s;
      int k;
      logic [7:0] delim;
      logic [7:0] limit;
      items_sent = 0;
      quiet_tail = 1'b0;
      hold_request = 1'b0;
      cur_delim = DELIMITER_RESET;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: empty string, leading and trailing space, empty and
      // trailing fields, byte extremes
      send_end();
      send_item(8'd32, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'd32, 1'b0);
      send_item(",", 1'b0);
      send_item(",", 1'b0);
      send_item(8'hff, 1'b0);
      send_item(",", 1'b0);
      send_end();

      // backslash delimiter with escapes, removal and a limit of one
      set_config(BACKSLASH, 1'b1, 1'b1, 8'd1);
      send_end();
      send_item("x", 1'b0);
      send_item(BACKSLASH, 1'b0);
      send_end();
      send_item(BACKSLASH, 1'b0);
      send_end();
      send_item(BACKSLASH, 1'b0);
      send_item(BACKSLASH, 1'b0);
      send_item(8'd32, 1'b0);
      send_item("y", 1'b0);
      send_end();

      // whitespace delimiter: leading empty field turns the rest into one field
      set_config(WS_DELIM, 1'b1, 1'b0, 8'd1);
      send_item(8'd32, 1'b0);
      send_item("p", 1'b0);
      send_item(8'd9, 1'b0);
      send_item("q", 1'b0);
      send_end();

      phase = 0;
      while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
         case (phase)
            0: set_config(DELIMITER_RESET, 1'b0, 1'b0, 8'd0);
            1: set_config(8'd0, 1'b0, 1'b1, 8'd2);
            2: set_config(WS_DELIM, 1'b1, 1'b1, 8'd255);
            3: set_config(BACKSLASH, 1'b1, 1'b1, 8'd1);
            4: set_config(8'd255, 1'b1, 1'b0, 8'd3);
            default: begin
               k = $urandom_range(0, 5);
               delim = (k == 0) ? DELIMITER_RESET : (k == 1) ? WS_DELIM :
                       (k == 2) ? BACKSLASH : (k == 3) ? 8'd0 : (k == 4) ? 8'd255 :
                       8'($urandom_range(0, 255));
               k = $urandom_range(0, 5);
               limit = (k < 4) ? 8'(k) : (k == 4) ? 8'd255 : 8'($urandom_range(0, 255));
               set_config(delim, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), limit);
            end
         endcase
         if (phase == 1) begin
            hold_request = 1'b1;
         end
         if (phase == 0) begin
            // enough fields to saturate the field number
            repeat (260) send_item(DELIMITER_RESET, 1'b0);
            send_end();
         end else begin
            n_str = $urandom_range(4, 10);
            for (s = 0; s < n_str; s++) begin
               send_random_string((phase == 1 && s == 0) || $urandom_range(0, 7) == 0);
            end
         end
         phase++;
      end

      // last part of the run: no idling on either side
      quiet_tail = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         send_random_string($urandom_range(0, 7) == 0);
      end

      settle();
      if (mismatch_count == 0 && results_due == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
